>>> rtl/pfl_pkg.sv
// ----------------------------------------------------------------------------
// Page frame free list package
// Field widths, command codes and the control and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfl_pkg;

    // Default geometry of a page and of the frame index.
    localparam int PAGE_BITS_DEF  = 12;
    localparam int FRAME_BITS_DEF = 16;

    // Fixed field widths of the streams.
    localparam int CMD_W     = 3;
    localparam int ADDR_W    = 28;
    localparam int LEN_W     = 29;
    localparam int BYTES_W   = 29;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 64;

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FINISH = 3'd4;

    // Controller to datapath commands.
    typedef struct packed {
        logic exec;        // a transaction is accepted: start its command
        logic add_step;    // push the next page of the region being added
        logic alloc_done;  // link read data is ready: finish the pop
        logic load_out;    // move the result into the output register
    } t_ctrl_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic add_more;    // the region walk still has pages to push
    } t_dp_status;

endpackage

>>> rtl/pfl_ctrl.sv
// ----------------------------------------------------------------------------
// Page frame free list controller
// Sequences each command through its states and owns the handshakes of both
// streams.
// ----------------------------------------------------------------------------
module pfl_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [pfl_pkg::CMD_W-1:0]   i_command,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output pfl_pkg::t_ctrl_cmd          o_cmd,
    input  pfl_pkg::t_dp_status         i_status
);
    import pfl_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ADD   = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       accept;

    // A new transaction is taken whenever no command is in progress.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;

    // Commands to the datapath.
    always_comb begin
        o_cmd.exec       = accept;
        o_cmd.add_step   = (r_state == S_ADD) && i_status.add_more;
        o_cmd.alloc_done = (r_state == S_ALLOC);
        o_cmd.load_out   = (r_state == S_RESP) && (!r_out_valid || i_m_axis_tready);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        CMD_ADD:   n_state = S_ADD;
                        CMD_ALLOC: n_state = S_ALLOC;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_ADD: begin
                if (!i_status.add_more) begin
                    n_state = S_RESP;
                end
            end
            S_ALLOC: n_state = S_RESP;
            S_RESP: begin
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/pfl_datapath.sv
// ----------------------------------------------------------------------------
// Page frame free list datapath
// Holds the head frame, the free count, the link table and the region walk,
// and builds the result transaction.
// ----------------------------------------------------------------------------
module pfl_datapath #(
    parameter int PAGE_BITS  = pfl_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS = pfl_pkg::FRAME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pfl_pkg::t_ctrl_cmd              i_cmd,
    output pfl_pkg::t_dp_status             o_status,
    input  logic [pfl_pkg::CMD_W-1:0]       i_command,
    input  logic [pfl_pkg::ADDR_W-1:0]      i_region_base,
    input  logic [pfl_pkg::LEN_W-1:0]       i_region_length,
    input  logic                            i_region_usable,
    input  logic [pfl_pkg::ADDR_W-1:0]      i_page_address,
    output logic [pfl_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);
    import pfl_pkg::*;

    // Tracked range is below 2^LIM_W bytes.
    localparam int LIM_W   = (FRAME_BITS + PAGE_BITS < ADDR_W) ?
                             (FRAME_BITS + PAGE_BITS) : ADDR_W;
    // Width of a region walk index; it can hold the frame count of the range.
    localparam int IT_W    = ADDR_W + 1 - PAGE_BITS;
    localparam int PF_W    = ADDR_W - PAGE_BITS;
    localparam int WF_W    = (IT_W > FRAME_BITS) ? IT_W : FRAME_BITS;
    localparam int CNT_W   = FRAME_BITS + 1;
    localparam int AW_W    = (FRAME_BITS + PAGE_BITS > ADDR_W) ?
                             (FRAME_BITS + PAGE_BITS) : ADDR_W;
    localparam int BW_W    = (CNT_W + PAGE_BITS > BYTES_W + 1) ?
                             (CNT_W + PAGE_BITS) : (BYTES_W + 1);
    localparam int DEPTH   = 1 << FRAME_BITS;
    localparam logic [IT_W:0]     LIM_FRAMES = (IT_W + 1)'(1) << (LIM_W - PAGE_BITS);
    localparam logic [BW_W-1:0]   BYTES_MAX  = BW_W'({BYTES_W{1'b1}});
    localparam logic [ADDR_W:0]   PAGE_MASK  = (ADDR_W + 1)'({PAGE_BITS{1'b1}});

    logic [FRAME_BITS-1:0] r_head;
    logic [FRAME_BITS-1:0] n_head;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [IT_W-1:0]       r_iter;
    logic [IT_W-1:0]       n_iter;
    logic [IT_W-1:0]       r_end;
    logic [IT_W-1:0]       n_end;
    logic [ADDR_W-1:0]     r_res_addr;
    logic [ADDR_W-1:0]     n_res_addr;
    logic                  r_res_ok;
    logic                  n_res_ok;
    logic                  r_res_failed;
    logic                  n_res_failed;
    logic [M_TDATA_W-1:0]  r_m_tdata;
    logic [FRAME_BITS-1:0] r_link [DEPTH];
    logic [FRAME_BITS-1:0] r_rd_link;

    logic [ADDR_W:0]       base_up;
    logic [ADDR_W+1:0]     region_top;
    logic [IT_W-1:0]       start_frame;
    logic [IT_W:0]         end_raw;
    logic [IT_W-1:0]       end_clip;
    logic [PF_W-1:0]       page_frame_raw;
    logic [WF_W-1:0]       page_wide;
    logic [WF_W-1:0]       iter_wide;
    logic                  free_ok;
    logic [AW_W-1:0]       alloc_wide;
    logic [BW_W-1:0]       bytes_wide;
    logic [BYTES_W-1:0]    free_bytes;
    logic                  push_req;
    logic                  push_en;
    logic [FRAME_BITS-1:0] push_frame;

    // Region bounds in frames: start rounded up, end rounded down and clipped.
    assign base_up     = {1'b0, i_region_base} + PAGE_MASK;
    assign start_frame = base_up[ADDR_W:PAGE_BITS];
    assign region_top  = {2'b00, i_region_base} + {1'b0, i_region_length};
    assign end_raw     = region_top[ADDR_W+1:PAGE_BITS];
    assign end_clip    = (end_raw > LIM_FRAMES) ? LIM_FRAMES[IT_W-1:0] : end_raw[IT_W-1:0];

    assign o_status.add_more = (r_iter < r_end);
    assign iter_wide         = WF_W'(r_iter);

    // A freed page must be nonzero, page aligned and inside the tracked range.
    assign page_frame_raw = i_page_address[ADDR_W-1:PAGE_BITS];
    assign page_wide      = WF_W'(page_frame_raw);
    assign free_ok        = (i_page_address != '0) &&
                            (i_page_address[PAGE_BITS-1:0] == '0) &&
                            ((IT_W + 1)'(page_frame_raw) < LIM_FRAMES);

    assign alloc_wide = AW_W'({r_head, {PAGE_BITS{1'b0}}});

    // Free bytes after the command, saturated to the field width.
    assign bytes_wide = BW_W'(r_count) << PAGE_BITS;
    assign free_bytes = (bytes_wide > BYTES_MAX) ? {BYTES_W{1'b1}} : bytes_wide[BYTES_W-1:0];

    // Command execution and the shared push path.
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_iter       = r_iter;
        n_end        = r_end;
        n_res_addr   = r_res_addr;
        n_res_ok     = r_res_ok;
        n_res_failed = r_res_failed;
        push_req     = 1'b0;
        push_frame   = '0;
        if (i_cmd.exec) begin
            n_res_addr   = '0;
            n_res_ok     = 1'b0;
            n_res_failed = 1'b0;
            unique case (i_command)
                CMD_CLEAR: begin
                    n_head  = '0;
                    n_count = '0;
                end
                CMD_ADD: begin
                    n_iter = start_frame;
                    n_end  = i_region_usable ? end_clip : '0;
                end
                CMD_FREE: begin
                    if (free_ok) begin
                        push_req   = 1'b1;
                        push_frame = page_wide[FRAME_BITS-1:0];
                        n_res_ok   = 1'b1;
                    end
                end
                CMD_FINISH: n_res_failed = (r_head == '0);
                default: ;
            endcase
        end else if (i_cmd.add_step) begin
            push_req   = 1'b1;
            push_frame = iter_wide[FRAME_BITS-1:0];
            n_iter     = r_iter + 1'b1;
        end else if (i_cmd.alloc_done) begin
            if (r_head != '0) begin
                n_res_addr = alloc_wide[ADDR_W-1:0];
                n_head     = r_rd_link;
                n_res_ok   = 1'b1;
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
            end
        end

        // Frame zero marks the empty list and is never pushed.
        push_en = push_req && (push_frame != '0);
        if (push_en) begin
            n_head = push_frame;
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    // List head and free count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Walk bounds, result fields and the output payload.
    always_ff @(posedge i_clk) begin
        r_iter       <= n_iter;
        r_end        <= n_end;
        r_res_addr   <= n_res_addr;
        r_res_ok     <= n_res_ok;
        r_res_failed <= n_res_failed;
        if (i_cmd.load_out) begin
            r_m_tdata <= M_TDATA_W'({r_res_failed, free_bytes, r_res_ok, r_res_addr});
        end
    end

    // Link table: the pushed frame stores the old head; the head link is
    // read every cycle so that it is ready in the cycle after an allocate.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_link[push_frame] <= r_head;
        end
        r_rd_link <= r_link[r_head];
    end

    assign o_m_axis_tdata = r_m_tdata;

endmodule

>>> rtl/page_frame_free_list_core.sv
// ----------------------------------------------------------------------------
// Page frame free list core
// Last-in-first-out pool of physical page frames with one result per command.
// ----------------------------------------------------------------------------
// Each input transaction carries one command and gives exactly one result.
// Clear, free, finish init and unused codes go from acceptance straight to
// the response state; allocate passes through an extra state first, because
// the head frame's link comes from a registered read of the link table; add
// region first walks every page in the rounded and clipped region, writing
// one link table entry a cycle. The next
// command is accepted as soon as the previous result has moved into the
// output register, even while that result still waits to be taken. The link
// table needs no clearing pass after reset.
module page_frame_free_list_core #(
    parameter int PAGE_BITS  = pfl_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS = pfl_pkg::FRAME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [27:0] region_base, [56:28] region_length, [57] region_usable,
    // [85:58] page_address, [87:86] zero
    input  logic [pfl_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // [2:0] command
    input  logic [pfl_pkg::CMD_W-1:0]       i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [27:0] allocated_address, [28] success, [57:29] free_bytes,
    // [58] init_failed, [63:59] zero
    output logic [pfl_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);
    import pfl_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Controller.
    pfl_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_command       (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_cmd           (cmd),
        .i_status        (status)
    );

    // Datapath with the link table.
    pfl_datapath #(
        .PAGE_BITS  (PAGE_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_command       (i_s_axis_tuser),
        .i_region_base   (i_s_axis_tdata[27:0]),
        .i_region_length (i_s_axis_tdata[56:28]),
        .i_region_usable (i_s_axis_tdata[57]),
        .i_page_address  (i_s_axis_tdata[85:58]),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

>>> dv/tb_page_frame_free_list_core.sv
// ----------------------------------------------------------------------------
// Page frame free list core testbench
// Drives command transactions into the free list and checks every result
// against an in-bench model of the pool's head, free count and link table.
// ----------------------------------------------------------------------------
module tb_page_frame_free_list_core;

    import pfl_pkg::*;

    // Pool geometry, taken from the block's default parameters.
    localparam int          PG_BITS     = PAGE_BITS_DEF;
    localparam int          FR_BITS     = FRAME_BITS_DEF;
    localparam bit [31:0]   PG_SIZE     = 32'd1 << PG_BITS;
    localparam bit [31:0]   PG_MASK     = PG_SIZE - 32'd1;
    localparam bit [63:0]   FULL_SPAN   = 64'd1 << (FR_BITS + PG_BITS);
    localparam bit [63:0]   ADDR_SPAN   = 64'd1 << ADDR_W;
    localparam bit [31:0]   TRACK_LIMIT = 32'((FULL_SPAN < ADDR_SPAN) ? FULL_SPAN : ADDR_SPAN);
    localparam bit [63:0]   BYTES_MAX   = (64'd1 << BYTES_W) - 64'd1;

    // Command codes that the block does not use.
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    // Run shape.
    localparam int RANDOM_ITEMS  = 1300;
    localparam int TAIL_ITEMS    = 150;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int WATCHDOG_MAX  = 300000;
    localparam int SPARE_MAX     = 64;

    // One command transaction.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] page;
        logic              usable;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] base;
    } t_req;

    // One result transaction, laid out as the output tdata.
    typedef struct packed {
        logic [4:0]         zero_pad;
        logic               init_failed;
        logic [BYTES_W-1:0] free_bytes;
        logic               success;
        logic [ADDR_W-1:0]  alloc_addr;
    } t_resp;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [CMD_W-1:0]     s_tuser     = '0;
    logic                 m_tready    = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    // Pool model state.
    bit [FR_BITS-1:0] pool_head;
    bit [FR_BITS:0]   pool_count;
    bit [FR_BITS-1:0] pool_link [1 << FR_BITS];

    t_req        pending_cmds [$];
    t_resp       results_due  [$];
    bit [27:0]   spare_pages  [$];
    t_req        cur_cmd;
    logic        in_tail      = 1'b0;
    int          mismatches   = 0;
    int          n_recv       = 0;
    int          quiet_cycles = 0;
    int          tx_gap       = 0;
    int          tx_idle_pct  = 0;
    int          rx_gap       = 0;
    int          rx_idle_pct  = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;

    page_frame_free_list_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock with a period of two time units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Push one frame onto the pool; frame zero marks an empty list.
    function automatic void push_frame(input bit [FR_BITS-1:0] frame);
        if (frame != '0) begin
            pool_link[frame] = pool_head;
            pool_head = frame;
            if (pool_count != '1) begin
                pool_count++;
            end
        end
    endfunction

    // Apply one command to the pool model and return the result it gives.
    function automatic t_resp pool_step(input t_req r);
        t_resp     res;
        bit [31:0] start;
        bit [31:0] stop;
        bit [31:0] a;
        bit [31:0] head_addr;
        bit [63:0] bytes;
        res = '0;
        case (r.cmd)
            CMD_CLEAR: begin
                pool_head  = '0;
                pool_count = '0;
            end
            CMD_ADD: begin
                if (r.usable) begin
                    // Round the start up and the end down to whole pages.
                    start = (32'(r.base) + PG_MASK) & ~PG_MASK;
                    stop  = (32'(r.base) + 32'(r.len)) & ~PG_MASK;
                    if (stop > TRACK_LIMIT) begin
                        stop = TRACK_LIMIT;
                    end
                    for (a = start; a < stop; a += PG_SIZE) begin
                        push_frame(FR_BITS'(a >> PG_BITS));
                    end
                end
            end
            CMD_ALLOC: begin
                if (pool_head != '0) begin
                    head_addr      = 32'(pool_head) << PG_BITS;
                    res.alloc_addr = head_addr[ADDR_W-1:0];
                    pool_head      = pool_link[pool_head];
                    if (pool_count != '0) begin
                        pool_count--;
                    end
                    res.success = 1'b1;
                end
            end
            CMD_FREE: begin
                if (r.page != '0 && (32'(r.page) & PG_MASK) == '0 &&
                    32'(r.page) < TRACK_LIMIT) begin
                    push_frame(FR_BITS'(32'(r.page) >> PG_BITS));
                    res.success = 1'b1;
                end
            end
            CMD_FINISH: begin
                res.init_failed = (pool_head == '0);
            end
            default: begin
            end
        endcase
        bytes = 64'(pool_count) << PG_BITS;
        if (bytes > BYTES_MAX) begin
            bytes = BYTES_MAX;
        end
        res.free_bytes = bytes[BYTES_W-1:0];
        return res;
    endfunction

    // Idling level for a stretch of traffic: none, light or heavy.
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] base,
                             input logic [LEN_W-1:0] len, input logic usable,
                             input logic [ADDR_W-1:0] page);
        t_req r;
        r.cmd    = cmd;
        r.base   = base;
        r.len    = len;
        r.usable = usable;
        r.page   = page;
        pending_cmds.push_back(r);
    endtask

    task automatic report_diff(input string fld, input logic [63:0] want,
                               input logic [63:0] seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("result %0d %s: expected 0x%0h, got 0x%0h", n_recv, fld, want, seen);
        end
    endtask

    // Sender: offers queued commands, predicts each accepted transaction.
    always @(posedge i_clk) begin : tx_side
        logic nxt_valid;
        t_req nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            in_tail  <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            nxt       = cur_cmd;
            if (s_tvalid && o_s_axis_tready) begin
                results_due.push_back(pool_step(cur_cmd));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_cmds.size() > 0) begin
                    if (!in_tail && $urandom_range(0, 99) < tx_idle_pct) begin
                        tx_gap = $urandom_range(1, 15) - 1;
                    end else begin
                        nxt       = pending_cmds.pop_front();
                        nxt_valid = 1'b1;
                        if ($urandom_range(0, 49) == 0) begin
                            tx_idle_pct = pick_idle_pct();
                        end
                    end
                end
            end
            cur_cmd  <= nxt;
            s_tvalid <= nxt_valid;
            s_tdata  <= {2'b00, nxt.page, nxt.usable, nxt.len, nxt.base};
            s_tuser  <= nxt.cmd;
            in_tail  <= (pending_cmds.size() < TAIL_ITEMS);
        end
    end

    // Receiver: checks each result transaction and drives tready, with
    // one long hold-off so that the block backs up and stalls its input.
    always @(posedge i_clk) begin : rx_side
        t_resp seen;
        t_resp want;
        logic  rdy;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                seen = t_resp'(o_m_axis_tdata);
                n_recv++;
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d unexpected, data 0x%0h", n_recv, o_m_axis_tdata);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (seen.alloc_addr !== want.alloc_addr) begin
                        report_diff("allocated_address", 64'(want.alloc_addr),
                                    64'(seen.alloc_addr));
                    end
                    if (seen.success !== want.success) begin
                        report_diff("success", 64'(want.success), 64'(seen.success));
                    end
                    if (seen.free_bytes !== want.free_bytes) begin
                        report_diff("free_bytes", 64'(want.free_bytes), 64'(seen.free_bytes));
                    end
                    if (seen.init_failed !== want.init_failed) begin
                        report_diff("init_failed", 64'(want.init_failed),
                                    64'(seen.init_failed));
                    end
                end
                if ($urandom_range(0, 49) == 0) begin
                    rx_idle_pct = pick_idle_pct();
                end
            end
            if (n_recv >= HOLD_AT && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                rdy = 1'b0;
            end else if (!in_tail && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_gap = $urandom_range(1, 15) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // Watchdog: ends the run after too long without any transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("page_frame_free_list_core: mismatch");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        t_req      r;
        int        k;
        int        pick;
        bit [31:0] first_page;

        // Directed: empty pool, ignored frees and regions, clipping,
        // a double free that loops the list, and count saturation.
        queue_cmd(CMD_ALLOC,  '0, '0, 1'b0, '0);
        queue_cmd(CMD_FINISH, '0, '0, 1'b0, '0);
        queue_cmd(CMD_FREE,   '0, '0, 1'b0, '0);
        queue_cmd(CMD_ADD,    28'h0001000, 29'h0010000, 1'b0, '0);
        queue_cmd(CMD_ADD,    28'h0001001, 29'h0001000, 1'b1, '0);
        queue_cmd(CMD_ADD,    28'h0000000, 29'h0005000, 1'b1, '0);
        queue_cmd(CMD_FINISH, '0, '0, 1'b0, '0);
        queue_cmd(CMD_ALLOC,  '0, '0, 1'b0, '0);
        queue_cmd(CMD_FREE,   '0, '0, 1'b0, 28'h0003004);
        queue_cmd(CMD_FREE,   '0, '0, 1'b0, 28'hFFFF000);
        queue_cmd(CMD_FREE,   '0, '0, 1'b0, 28'hFFFFFFF);
        queue_cmd(CMD_RSVD7,  28'hFFFFFFF, 29'h1FFFFFFF, 1'b1, 28'hFFFFFFF);
        queue_cmd(CMD_ADD,    28'hFFFFFFF, 29'h1FFFFFFF, 1'b1, '0);
        queue_cmd(CMD_ADD,    28'hFFF8001, 29'h1FFFFFFF, 1'b1, '0);
        queue_cmd(CMD_CLEAR,  '0, '0, 1'b0, '0);
        queue_cmd(CMD_FREE,   '0, '0, 1'b0, 28'h0005000);
        queue_cmd(CMD_FREE,   '0, '0, 1'b0, 28'h0005000);
        queue_cmd(CMD_ALLOC,  '0, '0, 1'b0, '0);
        queue_cmd(CMD_ALLOC,  '0, '0, 1'b0, '0);
        queue_cmd(CMD_ALLOC,  '0, '0, 1'b0, '0);
        queue_cmd(CMD_CLEAR,  '0, '0, 1'b0, '0);
        queue_cmd(CMD_ADD,    28'h0000000, 29'h10000000, 1'b1, '0);
        queue_cmd(CMD_ADD,    28'h0000000, 29'h1FFFFFFF, 1'b1, '0);
        queue_cmd(CMD_FREE,   '0, '0, 1'b0, 28'h0001000);
        queue_cmd(CMD_FREE,   '0, '0, 1'b0, 28'h0002000);
        queue_cmd(CMD_ALLOC,  '0, '0, 1'b0, '0);
        queue_cmd(CMD_CLEAR,  '0, '0, 1'b0, '0);

        // Random: mostly regions, allocations and frees of known pages,
        // with unused fields carrying noise throughout.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            r.base   = 28'($urandom);
            r.len    = 29'($urandom);
            r.usable = 1'($urandom);
            r.page   = 28'($urandom);
            pick     = $urandom_range(0, 99);
            if (pick < 30) begin
                r.cmd = CMD_ALLOC;
            end else if (pick < 55) begin
                r.cmd = CMD_FREE;
                pick  = $urandom_range(0, 99);
                if (pick < 60 && spare_pages.size() > 0) begin
                    r.page = spare_pages[$urandom_range(0, spare_pages.size() - 1)];
                end else if (pick < 75) begin
                    r.page = {16'($urandom), 12'h000};
                end else if (pick < 90) begin
                    r.page = 28'($urandom);
                end else if (pick < 95) begin
                    r.page = '0;
                end else begin
                    r.page = 28'hFFFF000;
                end
            end else if (pick < 75) begin
                r.cmd    = CMD_ADD;
                r.usable = ($urandom_range(0, 9) != 0);
                pick     = $urandom_range(0, 99);
                if (pick < 12) begin
                    // Region running past the top of the tracked range.
                    r.base = 28'(TRACK_LIMIT - $urandom_range(1, 8 * PG_SIZE));
                end else if (pick < 14) begin
                    r.len = 29'($urandom_range(0, 256 * PG_SIZE));
                end else begin
                    r.len = 29'($urandom_range(0, 16 * PG_SIZE));
                end
                first_page = (32'(r.base) + PG_MASK) & ~PG_MASK;
                if (r.usable && first_page != '0 && first_page < TRACK_LIMIT) begin
                    spare_pages.push_back(first_page[27:0]);
                    if (spare_pages.size() > SPARE_MAX) begin
                        void'(spare_pages.pop_front());
                    end
                end
            end else if (pick < 87) begin
                r.cmd = CMD_FINISH;
            end else if (pick < 91) begin
                r.cmd = CMD_CLEAR;
            end else begin
                r.cmd = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
            end
            pending_cmds.push_back(r);
        end

        // Single reset at the start of the run.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("page_frame_free_list_core: match");
        end else begin
            $display("page_frame_free_list_core: mismatch");
        end
        $finish;
    end

endmodule

>>> page_frame_free_list_core.f
rtl/pfl_pkg.sv
rtl/pfl_ctrl.sv
rtl/pfl_datapath.sv
rtl/page_frame_free_list_core.sv
dv/tb_page_frame_free_list_core.sv
